// ----- design/sm83_subset_fetch_execute_core_assert.svh -----
// Assertion macros for the SM83 subset core checker.
// Used by design/sm83fe_checker.sv; needs clk and rst_n in scope.
`ifndef SM83_SUBSET_FETCH_EXECUTE_CORE_ASSERT_SVH
`define SM83_SUBSET_FETCH_EXECUTE_CORE_ASSERT_SVH

// same-cycle implication
`define SM83FE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SM83FE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/sm83fe_pkg.sv -----
// Shared types and constants for the SM83 subset fetch/execute core.
// No dependencies.
`timescale 1ns / 1ps
package sm83fe_pkg;

  localparam int unsigned InqDepth  = 2;
  localparam int unsigned OutqDepth = 4;
  localparam logic [15:0] StartPcRst = 16'h0100;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_HALT  = 2'd2;

  localparam logic OP_START = 1'b0;

  localparam logic [7:0] OPC_NOP   = 8'h00;
  localparam logic [7:0] OPC_LDBC  = 8'h01;
  localparam logic [7:0] OPC_DECBC = 8'h0B;
  localparam logic [7:0] OPC_LDDE  = 8'h11;
  localparam logic [7:0] OPC_INCDE = 8'h13;
  localparam logic [7:0] OPC_LDADE = 8'h1A;
  localparam logic [7:0] OPC_LDHL  = 8'h21;
  localparam logic [7:0] OPC_STHLI = 8'h22;
  localparam logic [7:0] OPC_LDAD8 = 8'h3E;
  localparam logic [7:0] OPC_LDAB  = 8'h78;
  localparam logic [7:0] OPC_ORC   = 8'hB1;
  localparam logic [7:0] OPC_JPNZ  = 8'hC2;
  localparam logic [7:0] OPC_JP    = 8'hC3;
  localparam logic [7:0] OPC_JPC   = 8'hDA;
  localparam logic [7:0] OPC_STA16 = 8'hEA;
  localparam logic [7:0] OPC_LDA16 = 8'hFA;
  localparam logic [7:0] OPC_CPD8  = 8'hFE;

  localparam logic [1:0] ADDR_START_PC = 2'd0;

  typedef enum logic [2:0] {
    PH_IDLE, PH_FETCH, PH_IMM_LO, PH_IMM_HI, PH_DATA
  } phase_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] read_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  request_kind;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [15:0] program_counter;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic       is_start;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic take;
  } link_t;

  function automatic out_item_t mk_res(logic [1:0] kind, logic [15:0] addr,
                                       logic [7:0] wd, logic [15:0] pc,
                                       logic lst);
    out_item_t r;
    r.request_kind    = kind;
    r.address         = addr;
    r.write_data      = wd;
    r.program_counter = pc;
    r.last            = lst;
    return r;
  endfunction

endpackage

// ----- design/sm83fe_front.sv -----
// Front end: input item queue and start/read-data classification.
// Depends on sm83fe_pkg.
`timescale 1ns / 1ps
module sm83fe_front #(
  parameter int unsigned DEPTH = sm83fe_pkg::InqDepth
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  sm83fe_pkg::in_item_t in_item,
  output sm83fe_pkg::cmd_t     cmd,
  input  logic                 cmd_take,
  output logic                 cmd_valid
);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  sm83fe_pkg::cmd_t mem_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic do_push, do_pop;

  assign full      = (cnt_r == CW'(DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = mem_r[rp_r];
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r].is_start <= (in_item.operation == sm83fe_pkg::OP_START);
      mem_r[wp_r].data     <= in_item.read_data;
    end
  end
endmodule

// ----- design/sm83fe_back.sv -----
// Back end: register file, phase sequencer and request generation.
// Depends on sm83fe_pkg.
`timescale 1ns / 1ps
module sm83fe_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [15:0]           start_pc,
  input  sm83fe_pkg::cmd_t      cmd,
  input  sm83fe_pkg::link_t     lnk,
  output logic [1:0]            res_n,
  output sm83fe_pkg::out_item_t res0,
  output sm83fe_pkg::out_item_t res1
);
  sm83fe_pkg::phase_t ph_r, ph_nxt;
  logic [15:0] pc_r, pc_nxt, bc_r, bc_nxt, de_r, de_nxt, hl_r, hl_nxt;
  logic [7:0]  a_r, a_nxt, op_r, op_nxt, lo_r, lo_nxt;
  logic [3:0]  f_r, f_nxt;
  logic        run_r, run_nxt;
  logic        go, do_fetch, do_wr, take_jp;
  logic [15:0] fpc, tgt, wr_addr;
  logic [7:0]  d, a_or;

  assign go  = lnk.valid && lnk.take;
  assign d   = cmd.data;
  assign tgt = {d, lo_r};
  assign a_or = a_r | bc_r[7:0];

  always_comb begin
    ph_nxt = ph_r; pc_nxt = pc_r; bc_nxt = bc_r; de_nxt = de_r; hl_nxt = hl_r;
    a_nxt = a_r; op_nxt = op_r; lo_nxt = lo_r; f_nxt = f_r; run_nxt = run_r;
    do_fetch = 1'b0; fpc = pc_r; do_wr = 1'b0; wr_addr = hl_r; take_jp = 1'b0;
    res_n = 2'd0;
    res0 = sm83fe_pkg::mk_res(sm83fe_pkg::KIND_READ, pc_r, 8'h00, pc_r, 1'b1);
    res1 = res0;
    if (go && cmd.is_start) begin
      run_nxt = 1'b1;
      do_fetch = 1'b1;
      fpc = start_pc;
    end else if (go && run_r) begin
      unique case (ph_r)
        sm83fe_pkg::PH_FETCH: begin
          op_nxt = d;
          unique case (d)
            sm83fe_pkg::OPC_NOP: begin
              do_fetch = 1'b1; fpc = pc_r + 16'd1;
            end
            sm83fe_pkg::OPC_INCDE: begin
              de_nxt = de_r + 16'd1; do_fetch = 1'b1; fpc = pc_r + 16'd1;
            end
            sm83fe_pkg::OPC_DECBC: begin
              bc_nxt = bc_r - 16'd1; do_fetch = 1'b1; fpc = pc_r + 16'd1;
            end
            sm83fe_pkg::OPC_LDAB: begin
              a_nxt = bc_r[15:8]; do_fetch = 1'b1; fpc = pc_r + 16'd1;
            end
            sm83fe_pkg::OPC_ORC: begin
              a_nxt = a_or; f_nxt = {(a_or == 8'h00), 3'b000};
              do_fetch = 1'b1; fpc = pc_r + 16'd1;
            end
            sm83fe_pkg::OPC_LDADE: begin
              ph_nxt = sm83fe_pkg::PH_DATA; res_n = 2'd1;
              res0 = sm83fe_pkg::mk_res(sm83fe_pkg::KIND_READ, de_r, 8'h00, pc_r, 1'b1);
            end
            sm83fe_pkg::OPC_STHLI: begin
              do_wr = 1'b1; wr_addr = hl_r; hl_nxt = hl_r + 16'd1;
              do_fetch = 1'b1; fpc = pc_r + 16'd1;
            end
            sm83fe_pkg::OPC_LDAD8, sm83fe_pkg::OPC_CPD8, sm83fe_pkg::OPC_JP,
            sm83fe_pkg::OPC_JPC, sm83fe_pkg::OPC_JPNZ, sm83fe_pkg::OPC_LDBC,
            sm83fe_pkg::OPC_LDDE, sm83fe_pkg::OPC_LDHL, sm83fe_pkg::OPC_STA16,
            sm83fe_pkg::OPC_LDA16: begin
              ph_nxt = sm83fe_pkg::PH_IMM_LO; res_n = 2'd1;
              res0 = sm83fe_pkg::mk_res(sm83fe_pkg::KIND_READ, pc_r + 16'd1, 8'h00,
                                        pc_r, 1'b1);
            end
            default: begin
              run_nxt = 1'b0; ph_nxt = sm83fe_pkg::PH_IDLE; res_n = 2'd1;
              res0 = sm83fe_pkg::mk_res(sm83fe_pkg::KIND_HALT, pc_r, 8'h00, pc_r, 1'b1);
            end
          endcase
        end
        sm83fe_pkg::PH_IMM_LO: begin
          if (op_r == sm83fe_pkg::OPC_LDAD8) begin
            a_nxt = d; do_fetch = 1'b1; fpc = pc_r + 16'd2;
          end else if (op_r == sm83fe_pkg::OPC_CPD8) begin
            f_nxt = {(a_r == d), 1'b1, (a_r[3:0] < d[3:0]), (a_r < d)};
            do_fetch = 1'b1; fpc = pc_r + 16'd2;
          end else begin
            lo_nxt = d; ph_nxt = sm83fe_pkg::PH_IMM_HI; res_n = 2'd1;
            res0 = sm83fe_pkg::mk_res(sm83fe_pkg::KIND_READ, pc_r + 16'd2, 8'h00,
                                      pc_r, 1'b1);
          end
        end
        sm83fe_pkg::PH_IMM_HI: begin
          do_fetch = 1'b1; fpc = pc_r + 16'd3;
          unique case (op_r)
            sm83fe_pkg::OPC_JP:    take_jp = 1'b1;
            sm83fe_pkg::OPC_JPC:   take_jp = f_r[0];
            sm83fe_pkg::OPC_JPNZ:  take_jp = !f_r[3];
            sm83fe_pkg::OPC_LDBC:  bc_nxt = tgt;
            sm83fe_pkg::OPC_LDDE:  de_nxt = tgt;
            sm83fe_pkg::OPC_LDHL:  hl_nxt = tgt;
            sm83fe_pkg::OPC_STA16: begin
              do_wr = 1'b1; wr_addr = tgt;
            end
            sm83fe_pkg::OPC_LDA16: begin
              do_fetch = 1'b0; ph_nxt = sm83fe_pkg::PH_DATA; res_n = 2'd1;
              res0 = sm83fe_pkg::mk_res(sm83fe_pkg::KIND_READ, tgt, 8'h00, pc_r, 1'b1);
            end
            default: take_jp = 1'b0;
          endcase
          if (take_jp) begin
            fpc = tgt;
          end
        end
        sm83fe_pkg::PH_DATA: begin
          a_nxt = d; do_fetch = 1'b1;
          fpc = pc_r + ((op_r == sm83fe_pkg::OPC_LDADE) ? 16'd1 : 16'd3);
        end
        default: res_n = 2'd0;
      endcase
    end
    if (do_fetch) begin
      pc_nxt = fpc;
      ph_nxt = sm83fe_pkg::PH_FETCH;
      if (do_wr) begin
        res_n = 2'd2;
        res0 = sm83fe_pkg::mk_res(sm83fe_pkg::KIND_WRITE, wr_addr, a_r, pc_r, 1'b0);
        res1 = sm83fe_pkg::mk_res(sm83fe_pkg::KIND_READ, fpc, 8'h00, fpc, 1'b1);
      end else begin
        res_n = 2'd1;
        res0 = sm83fe_pkg::mk_res(sm83fe_pkg::KIND_READ, fpc, 8'h00, fpc, 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= sm83fe_pkg::PH_IDLE;
      pc_r <= '0; bc_r <= '0; de_r <= '0; hl_r <= '0;
      a_r <= '0; op_r <= '0; lo_r <= '0; f_r <= '0; run_r <= 1'b1;
    end else begin
      ph_r <= ph_nxt;
      pc_r <= pc_nxt; bc_r <= bc_nxt; de_r <= de_nxt; hl_r <= hl_nxt;
      a_r <= a_nxt; op_r <= op_nxt; lo_r <= lo_nxt; f_r <= f_nxt; run_r <= run_nxt;
    end
  end
endmodule

// ----- design/sm83fe_outq.sv -----
// Result queue: takes up to two result items per cycle, gives one.
// Depends on sm83fe_pkg.
`timescale 1ns / 1ps
module sm83fe_outq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [1:0]            res_n,
  input  sm83fe_pkg::out_item_t res0,
  input  sm83fe_pkg::out_item_t res1,
  output logic                  room,
  output logic                  empty,
  input  logic                  pop,
  output sm83fe_pkg::out_item_t out_item
);
  localparam int unsigned PW = $clog2(sm83fe_pkg::OutqDepth);
  localparam int unsigned CW = $clog2(sm83fe_pkg::OutqDepth + 1);

  sm83fe_pkg::out_item_t mem_r [sm83fe_pkg::OutqDepth];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          do_pop;

  assign empty    = (cnt_r == '0);
  assign room     = (cnt_r <= CW'(sm83fe_pkg::OutqDepth - 2));
  assign out_item = mem_r[rp_r];
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + PW'(res_n);
      rp_r  <= rp_r + PW'(do_pop);
      cnt_r <= cnt_r + CW'(res_n) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (res_n != 2'd0) begin
      mem_r[wp_r] <= res0;
    end
    if (res_n == 2'd2) begin
      mem_r[wp_r + PW'(1)] <= res1;
    end
  end
endmodule

// ----- design/sm83_subset_fetch_execute_core.sv -----
// Top level of the SM83 subset fetch/execute core: config port and wiring.
// Depends on sm83fe_pkg, sm83fe_front, sm83fe_back, sm83fe_outq.
//
//   channel | handshake          | payload
//   input   | push / full        | in_item  (operation, read_data)
//   result  | pop / empty        | out_item (kind, address, data, pc, last)
//   config  | psel/penable/pwrite| paddr, pwdata, prdata (start_pc)
//
// One input item a cycle while the input queue is not full; each yields zero, one or two result items.
// The back end takes an item when the result queue has room for two.
// Input queue of IN_DEPTH items, result queue of four items.
// Synchronous active-low reset; start_pc resets to 0x0100.
`timescale 1ns / 1ps
module sm83_subset_fetch_execute_core #(
  parameter int unsigned IN_DEPTH = sm83fe_pkg::InqDepth
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  sm83fe_pkg::in_item_t  in_item,
  output logic                  empty,
  input  logic                  pop,
  output sm83fe_pkg::out_item_t out_item,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [1:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  logic [15:0]           start_pc_r;
  sm83fe_pkg::cmd_t      cmd;
  sm83fe_pkg::link_t     lnk;
  logic                  cmd_valid;
  logic                  room;
  logic [1:0]            res_n;
  sm83fe_pkg::out_item_t res0, res1;

  assign pready   = 1'b1;
  assign prdata   = (paddr == sm83fe_pkg::ADDR_START_PC) ? {16'h0000, start_pc_r} : 32'h0;
  assign lnk      = '{valid: cmd_valid, take: room};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_pc_r <= sm83fe_pkg::StartPcRst;
    end else if (psel && penable && pwrite && paddr == sm83fe_pkg::ADDR_START_PC) begin
      start_pc_r <= pwdata[15:0];
    end
  end

  sm83fe_front #(.DEPTH(IN_DEPTH)) u_front (
    .clk, .rst_n, .push, .full, .in_item,
    .cmd, .cmd_take(room), .cmd_valid(cmd_valid)
  );

  sm83fe_back u_back (
    .clk, .rst_n, .start_pc(start_pc_r), .cmd, .lnk, .res_n, .res0, .res1
  );

  sm83fe_outq u_outq (
    .clk, .rst_n, .res_n, .res0, .res1, .room, .empty, .pop, .out_item
  );
endmodule

// ----- design/sm83fe_checker.sv -----
// Port-level checker for the SM83 subset core, bound to the top level.
// Depends on sm83fe_pkg and sm83_subset_fetch_execute_core_assert.svh.
`timescale 1ns / 1ps
`include "sm83_subset_fetch_execute_core_assert.svh"
module sm83fe_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  empty,
  input logic                  pop,
  input sm83fe_pkg::out_item_t out_item
);
  logic kind_ok, is_wr, is_fetch;

  assign kind_ok  = (out_item.request_kind <= sm83fe_pkg::KIND_HALT);
  assign is_wr    = (out_item.request_kind == sm83fe_pkg::KIND_WRITE);
  assign is_fetch = out_item.last && (out_item.request_kind == sm83fe_pkg::KIND_READ) &&
                    (out_item.address == out_item.program_counter);

  `SM83FE_ASSERT_NOW(a_kind_ok, !empty, kind_ok, "bad kind")
  `SM83FE_ASSERT_NOW(a_notlast_wr, !empty && !out_item.last, is_wr, "non-final item not a write")
  `SM83FE_ASSERT_NXT(a_pair, !empty && pop && !out_item.last, !empty && is_fetch, "store not followed by fetch")
  `SM83FE_ASSERT_NXT(a_hold, !empty && !pop, !empty && $stable(out_item), "result dropped")
endmodule

bind sm83_subset_fetch_execute_core sm83fe_checker u_chk (
  .clk, .rst_n, .empty, .pop, .out_item
);

// ----- tb/sv/tb.sv -----
// Self-checking bench for the SM83 subset fetch/execute core: feeds start and
// read-data items, predicts the memory requests and compares them in order.
// Depends on sm83fe_pkg and sm83_subset_fetch_execute_core.
`timescale 1ns / 1ps
module tb;
  logic clk, rst_n, push, full, empty, pop;
  logic psel, penable, pwrite, pready;
  logic [1:0] paddr;
  logic [31:0] pwdata, prdata;
  sm83fe_pkg::in_item_t in_item;
  sm83fe_pkg::out_item_t out_item;

  sm83_subset_fetch_execute_core u_dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item), .psel(psel),
    .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  // core model state
  logic [15:0] m_start_pc, m_pc, m_bc, m_de, m_hl;
  logic [7:0] m_a, m_opc, m_lo;
  logic [3:0] m_flags;
  sm83fe_pkg::phase_t m_phase;
  logic m_running;

  sm83fe_pkg::in_item_t pending_items[$];
  sm83fe_pkg::out_item_t expected_reqs[$];
  int errors = 0;
  int mismatches = 0;
  longint cycles = 0;
  bit quiet = 0;
  bit send_pause = 0;
  bit in_taken = 0;
  int hold_cycles = 0;
  int gap_cycles = 0;
  int stall_cycles = 0;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic void emit(logic [1:0] kind, logic [15:0] addr, logic [7:0] wd,
                               logic lst);
    sm83fe_pkg::out_item_t r;
    r.request_kind = kind;
    r.address = addr;
    r.write_data = wd;
    r.program_counter = m_pc;
    r.last = lst;
    expected_reqs.push_back(r);
  endfunction

  function automatic void fetch_after(logic [15:0] len);
    m_pc = m_pc + len;
    m_phase = sm83fe_pkg::PH_FETCH;
    emit(sm83fe_pkg::KIND_READ, m_pc, 8'h00, 1'b1);
  endfunction

  function automatic void predict_core(sm83fe_pkg::in_item_t it);
    logic [7:0] d;
    logic [15:0] tgt;
    logic [3:0] f;
    d = it.read_data;
    if (it.operation == sm83fe_pkg::OP_START) begin
      m_pc = m_start_pc;
      m_running = 1'b1;
      fetch_after(16'd0);
      return;
    end
    if (!m_running) return;
    case (m_phase)
      sm83fe_pkg::PH_FETCH: begin
        m_opc = d;
        case (d)
          sm83fe_pkg::OPC_NOP: fetch_after(16'd1);
          sm83fe_pkg::OPC_INCDE: begin m_de = m_de + 16'd1; fetch_after(16'd1); end
          sm83fe_pkg::OPC_DECBC: begin m_bc = m_bc - 16'd1; fetch_after(16'd1); end
          sm83fe_pkg::OPC_LDAB: begin m_a = m_bc[15:8]; fetch_after(16'd1); end
          sm83fe_pkg::OPC_ORC: begin
            m_a = m_a | m_bc[7:0];
            m_flags = (m_a == 8'h00) ? 4'h8 : 4'h0;
            fetch_after(16'd1);
          end
          sm83fe_pkg::OPC_LDADE: begin
            m_phase = sm83fe_pkg::PH_DATA;
            emit(sm83fe_pkg::KIND_READ, m_de, 8'h00, 1'b1);
          end
          sm83fe_pkg::OPC_STHLI: begin
            emit(sm83fe_pkg::KIND_WRITE, m_hl, m_a, 1'b0);
            m_hl = m_hl + 16'd1;
            fetch_after(16'd1);
          end
          sm83fe_pkg::OPC_LDAD8, sm83fe_pkg::OPC_CPD8, sm83fe_pkg::OPC_JP,
          sm83fe_pkg::OPC_JPC, sm83fe_pkg::OPC_JPNZ, sm83fe_pkg::OPC_LDBC,
          sm83fe_pkg::OPC_LDDE, sm83fe_pkg::OPC_LDHL, sm83fe_pkg::OPC_STA16,
          sm83fe_pkg::OPC_LDA16: begin
            m_phase = sm83fe_pkg::PH_IMM_LO;
            emit(sm83fe_pkg::KIND_READ, m_pc + 16'd1, 8'h00, 1'b1);
          end
          default: begin
            m_running = 1'b0;
            m_phase = sm83fe_pkg::PH_IDLE;
            emit(sm83fe_pkg::KIND_HALT, m_pc, 8'h00, 1'b1);
          end
        endcase
      end
      sm83fe_pkg::PH_IMM_LO: begin
        if (m_opc == sm83fe_pkg::OPC_LDAD8) begin
          m_a = d;
          fetch_after(16'd2);
        end else if (m_opc == sm83fe_pkg::OPC_CPD8) begin
          f = 4'h4;
          if (m_a == d) f[3] = 1'b1;
          if (m_a[3:0] < d[3:0]) f[1] = 1'b1;
          if (m_a < d) f[0] = 1'b1;
          m_flags = f;
          fetch_after(16'd2);
        end else begin
          m_lo = d;
          m_phase = sm83fe_pkg::PH_IMM_HI;
          emit(sm83fe_pkg::KIND_READ, m_pc + 16'd2, 8'h00, 1'b1);
        end
      end
      sm83fe_pkg::PH_IMM_HI: begin
        tgt = {d, m_lo};
        case (m_opc)
          sm83fe_pkg::OPC_JP: begin m_pc = tgt; fetch_after(16'd0); end
          sm83fe_pkg::OPC_JPC:
            if (m_flags[0]) begin m_pc = tgt; fetch_after(16'd0); end
            else fetch_after(16'd3);
          sm83fe_pkg::OPC_JPNZ:
            if (!m_flags[3]) begin m_pc = tgt; fetch_after(16'd0); end
            else fetch_after(16'd3);
          sm83fe_pkg::OPC_LDBC: begin m_bc = tgt; fetch_after(16'd3); end
          sm83fe_pkg::OPC_LDDE: begin m_de = tgt; fetch_after(16'd3); end
          sm83fe_pkg::OPC_LDHL: begin m_hl = tgt; fetch_after(16'd3); end
          sm83fe_pkg::OPC_STA16: begin
            emit(sm83fe_pkg::KIND_WRITE, tgt, m_a, 1'b0);
            fetch_after(16'd3);
          end
          sm83fe_pkg::OPC_LDA16: begin
            m_phase = sm83fe_pkg::PH_DATA;
            emit(sm83fe_pkg::KIND_READ, tgt, 8'h00, 1'b1);
          end
          default: fetch_after(16'd3);
        endcase
      end
      sm83fe_pkg::PH_DATA: begin
        m_a = d;
        fetch_after(m_opc == sm83fe_pkg::OPC_LDADE ? 16'd1 : 16'd3);
      end
      default: ;
    endcase
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else if (in_taken) begin
      // item taken at the last rising edge: hand on or drop
      if (pending_items.size() > 0 && !send_pause && gap_cycles == 0 &&
          (quiet || $urandom_range(0, 7) != 0)) begin
        in_item <= pending_items[0];
      end else begin
        push <= 1'b0;
        if (!quiet && $urandom_range(0, 7) == 0) gap_cycles = $urandom_range(1, 6);
      end
    end else if (gap_cycles > 0) begin
      gap_cycles--;
    end else if (!push && pending_items.size() > 0 && !send_pause) begin
      in_item <= pending_items[0];
      push <= 1'b1;
    end
  end

  // monitor, input acceptance and result-side stalls
  always @(posedge clk) begin
    cycles++;
    in_taken = rst_n && push && !full;
    if (in_taken) predict_core(pending_items.pop_front());
    if (rst_n && pop && !empty) begin
      if (expected_reqs.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected request %p", out_item);
      end else begin
        if (out_item !== expected_reqs[0]) begin
          errors++;
          if (mismatches++ < 10)
            $display("request mismatch: expected %p actual %p", expected_reqs[0], out_item);
        end
        void'(expected_reqs.pop_front());
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles--;
      pop <= 1'b0;
    end else if (stall_cycles > 0) begin
      stall_cycles--;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
      if (!quiet && $urandom_range(0, 9) == 0) stall_cycles = $urandom_range(1, 6);
    end
  end

  task automatic add_item(logic op, logic [7:0] d);
    sm83fe_pkg::in_item_t it;
    it.operation = op;
    it.read_data = d;
    pending_items.push_back(it);
  endtask

  task automatic drain_all();
    while (pending_items.size() > 0 || push || expected_reqs.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_start_pc(logic [15:0] v);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= sm83fe_pkg::ADDR_START_PC; pwdata <= {16'h0, v};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    m_start_pc = v;
  endtask

  // one random instruction: opcode then its operand / data bytes
  task automatic add_instr();
    logic [7:0] opc;
    int pick;
    logic [7:0] opcs[17];
    opcs = '{sm83fe_pkg::OPC_NOP, sm83fe_pkg::OPC_LDBC, sm83fe_pkg::OPC_DECBC,
             sm83fe_pkg::OPC_LDDE, sm83fe_pkg::OPC_INCDE, sm83fe_pkg::OPC_LDADE,
             sm83fe_pkg::OPC_LDHL, sm83fe_pkg::OPC_STHLI, sm83fe_pkg::OPC_LDAD8,
             sm83fe_pkg::OPC_LDAB, sm83fe_pkg::OPC_ORC, sm83fe_pkg::OPC_JPNZ,
             sm83fe_pkg::OPC_JP, sm83fe_pkg::OPC_JPC, sm83fe_pkg::OPC_STA16,
             sm83fe_pkg::OPC_LDA16, sm83fe_pkg::OPC_CPD8};
    pick = $urandom_range(0, 99);
    if (pick < 3) opc = 8'($urandom());
    else opc = opcs[$urandom_range(0, 16)];
    add_item(1'b1, opc);
    case (opc)
      sm83fe_pkg::OPC_LDAD8, sm83fe_pkg::OPC_CPD8: add_item(1'b1, 8'($urandom()));
      sm83fe_pkg::OPC_JP, sm83fe_pkg::OPC_JPC, sm83fe_pkg::OPC_JPNZ,
      sm83fe_pkg::OPC_LDBC, sm83fe_pkg::OPC_LDDE, sm83fe_pkg::OPC_LDHL,
      sm83fe_pkg::OPC_STA16: begin
        add_item(1'b1, 8'($urandom())); add_item(1'b1, 8'($urandom()));
      end
      sm83fe_pkg::OPC_LDA16: begin
        add_item(1'b1, 8'($urandom())); add_item(1'b1, 8'($urandom()));
        add_item(1'b1, 8'($urandom()));
      end
      sm83fe_pkg::OPC_LDADE: add_item(1'b1, 8'($urandom()));
      default: ;
    endcase
  endtask

  initial begin
    int n;
    rst_n = 0; push = 0; pop = 0; in_item = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    m_start_pc = sm83fe_pkg::StartPcRst; m_pc = '0; m_a = '0; m_bc = '0; m_de = '0;
    m_hl = '0; m_flags = '0; m_phase = sm83fe_pkg::PH_IDLE; m_opc = '0; m_lo = '0;
    m_running = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: reads while idle, all opcodes but NOP, INCDE, LDBC and LDDE, flags, jumps, wrap and halt
    add_item(1'b1, 8'hFF);
    add_item(1'b0, 8'h00);
    add_item(1'b1, sm83fe_pkg::OPC_LDAD8); add_item(1'b1, 8'h00);
    add_item(1'b1, sm83fe_pkg::OPC_CPD8); add_item(1'b1, 8'hFF);
    add_item(1'b1, sm83fe_pkg::OPC_JPC); add_item(1'b1, 8'hFF); add_item(1'b1, 8'hFF);
    add_item(1'b1, sm83fe_pkg::OPC_JPNZ); add_item(1'b1, 8'h34); add_item(1'b1, 8'h12);
    add_item(1'b1, sm83fe_pkg::OPC_ORC);
    add_item(1'b1, sm83fe_pkg::OPC_LDHL); add_item(1'b1, 8'hFF); add_item(1'b1, 8'hFF);
    add_item(1'b1, sm83fe_pkg::OPC_STHLI);
    add_item(1'b1, sm83fe_pkg::OPC_DECBC);
    add_item(1'b1, sm83fe_pkg::OPC_LDAB);
    add_item(1'b1, 8'hD3);
    add_item(1'b1, 8'h55);
    add_item(1'b0, 8'hAA);
    drain_all();
    write_start_pc(16'hFFFE);
    add_item(1'b0, 8'h00);
    add_item(1'b1, sm83fe_pkg::OPC_JP); add_item(1'b1, 8'h00); add_item(1'b1, 8'h80);
    add_item(1'b1, sm83fe_pkg::OPC_STA16); add_item(1'b1, 8'hFF); add_item(1'b1, 8'hFF);
    add_item(1'b1, sm83fe_pkg::OPC_LDADE); add_item(1'b1, 8'h7E);
    add_item(1'b1, sm83fe_pkg::OPC_LDA16); add_item(1'b1, 8'h01); add_item(1'b1, 8'h00);
    add_item(1'b1, 8'h81);
    drain_all();
    write_start_pc(16'h0000);

    // long receiver hold-off with the sender still offering
    add_item(1'b0, 8'h00);
    repeat (20) add_item(1'b1, sm83fe_pkg::OPC_INCDE);
    hold_cycles = 60;
    drain_all();

    n = 0;
    while (n < 1350) begin
      if (n == 500) begin
        drain_all();
        write_start_pc(16'($urandom()));
      end
      if (n == 900) begin
        // send what is queued, then pause until all requests are back
        while (pending_items.size() > 0 || push) @(posedge clk);
        send_pause = 1;
        drain_all();
        send_pause = 0;
        write_start_pc(16'hFFFF);
      end
      if (n == 1150) quiet = 1;
      if ($urandom_range(0, 39) == 0) begin
        add_item(1'b0, 8'($urandom())); n++;
      end else if ($urandom_range(0, 49) == 0) begin
        add_item(1'b1, 8'($urandom())); n++;
      end else begin
        int before_sz;
        before_sz = pending_items.size();
        add_instr();
        n += pending_items.size() - before_sz;
      end
      while (pending_items.size() > 8) @(posedge clk);
    end
    drain_all();
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    while (cycles < 400000) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+design
design/sm83fe_pkg.sv
design/sm83fe_front.sv
design/sm83fe_back.sv
design/sm83fe_outq.sv
design/sm83_subset_fetch_execute_core.sv
design/sm83fe_checker.sv
tb/sv/tb.sv
